// ===== src/b64e_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64e_pkg;

    localparam int          QUEUE_DEPTH = 2;
    localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [6:0]  PAD_INDEX   = 7'd64;
    localparam logic [7:0]  PAD_CHAR    = 8'd61;

    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } b64e_phase_t;

    // One accepted byte turned into up to four character codes.
    typedef struct packed {
        logic [3:0][6:0] code;     // alphabet index, PAD_INDEX for '='
        logic [1:0]      cnt_m1;   // characters in this job minus one
        logic            fin;      // job closes the message
    } b64e_job_t;

    function automatic logic [7:0] b64e_char(input logic [6:0] idx);
        logic [7:0] c;
        if (idx < 7'd26)
            c = 8'd65 + {1'b0, idx};
        else if (idx < 7'd52)
            c = 8'd71 + {1'b0, idx};      // 'a' - 26
        else if (idx < 7'd62)
            c = {1'b0, idx} - 8'd4;       // '0' - 52
        else if (idx == 7'd62)
            c = 8'd43;
        else if (idx == 7'd63)
            c = 8'd47;
        else
            c = PAD_CHAR;
        return c;
    endfunction

endpackage

// ===== src/b64e_front.sv =====
// Front end: accepts bytes, tracks the group phase and builds character jobs.
module b64e_front
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  logic       q_full,
    output logic       push,
    output b64e_job_t  job
);

    b64e_phase_t phase_reg, phase_next;
    logic [3:0]  leftover_reg, leftover_next;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        job.code   = {PAD_INDEX, PAD_INDEX, PAD_INDEX, PAD_INDEX};
        job.fin    = final_byte;
        job.cnt_m1 = 2'd0;
        phase_next    = PHASE_FIRST;
        leftover_next = 4'd0;
        unique case (phase_reg)
            PHASE_SECOND:
            begin
                job.code[0] = {1'b0, leftover_reg[1:0], data_byte[7:4]};
                job.code[1] = {1'b0, data_byte[3:0], 2'b00};
                if (final_byte)
                    job.cnt_m1 = 2'd2;
                else
                begin
                    phase_next    = PHASE_THIRD;
                    leftover_next = data_byte[3:0];
                end
            end
            PHASE_THIRD:
            begin
                job.code[0] = {1'b0, leftover_reg, data_byte[7:6]};
                job.code[1] = {1'b0, data_byte[5:0]};
                job.cnt_m1  = 2'd1;
            end
            default:
            begin
                // first byte of a group; the unused phase code lands here too
                job.code[0] = {1'b0, data_byte[7:2]};
                job.code[1] = {1'b0, data_byte[1:0], 4'b0000};
                if (final_byte)
                    job.cnt_m1 = 2'd3;
                else
                begin
                    phase_next    = PHASE_SECOND;
                    leftover_next = {2'b00, data_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_FIRST;
            leftover_reg <= 4'd0;
        end
        else if (push)
        begin
            phase_reg    <= phase_next;
            leftover_reg <= leftover_next;
        end
    end

endmodule

// ===== src/b64e_queue.sv =====
// Short job queue between the front end and the character serializer.
module b64e_queue
    import b64e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  b64e_job_t push_job,
    input  logic      pop,
    output b64e_job_t head_job,
    output logic      full,
    output logic      empty
);

    b64e_job_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== src/b64e_back.sv =====
// Back end: walks each job one character per cycle into the output register, while the receiver is ready.
module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  b64e_job_t  head_job,
    input  logic       q_empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_char
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       load;
    logic       at_end;

    assign load   = !q_empty && (!valid_reg || out_ready);
    assign at_end = (idx_reg == head_job.cnt_m1);
    assign pop    = load && at_end;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= b64e_char(head_job.code[idx_reg]);
            last_reg <= head_job.fin && at_end;
        end
    end

endmodule

// ===== src/base64_stream_encoder.sv =====
// Top level of the streaming base64 encoder (standard alphabet, '=' padding).
//
// Input channel: in_valid/in_ready carry one message byte (data_byte) per
// transaction, final_byte set on the last byte of the message.
// Output channel: out_valid/out_ready carry one ASCII character (out_char)
// per transaction, last_char set on the final character of the message.
// Each byte yields one to four characters: one at group positions one and
// two, two at position three, and a final byte fills its group out to four
// characters with '=' padding.
// An accepted byte's job is written into the queue; its characters are then
// registered in the output register. The serializer emits one character per
// cycle while the receiver is ready, so throughput is set by the output side:
// on average 4/3 characters per byte, up to 4 for a final byte. A two-entry
// job queue lets bytes be accepted while the serializer is still busy;
// in_ready drops when the queue is full. A stalled receiver holds the
// output register and, once the queue fills, stalls the input side;
// nothing is dropped. Reset clears the group phase, the queue and the output
// valid; the next byte starts a new message.
module base64_stream_encoder
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_char
);

    b64e_job_t new_job, head_job;
    logic      push, pop, q_full, q_empty;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .push       (push),
        .job        (new_job)
    );

    b64e_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (new_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule
